### src/first_fit_interval_row_packer_defines.svh
// Assertion macros used by the row packer top level.
`ifndef FIRST_FIT_INTERVAL_ROW_PACKER_DEFINES_SVH
`define FIRST_FIT_INTERVAL_ROW_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define FFRP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("property failed");
`define FFRP_ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden state");
`else
`define FFRP_ASSERT(name, clk, rst, prop)
`define FFRP_ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

### src/ffrp_pkg.sv
// Shared constants and types of the row packer.
package ffrp_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_CELLS  = 1024;
  localparam int DEF_MAX_RANGES = 4;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int SCALE_W    = 25;
  localparam int CELLS_W    = 11;
  localparam int ROWS_W     = 7;
  localparam int ROW_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PART_W   = 17;
  localparam int PROD_W   = PART_W + SCALE_W;
  localparam int ACC_W    = 59;
  localparam int FRAC_W   = 24;
  localparam int RND_W    = ACC_W - FRAC_W;
  localparam int WORD_W   = 64;
  localparam int WORD_SH  = 6;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_WIN_START      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q24      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_ROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_OVERFLOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DO_PADDING     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_NEW_ROW  = 3'd6;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd16777216;
  localparam logic [CELLS_W-1:0] CELLS_RESET = 11'd800;
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 7'd64;

  localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic start;
    logic pad;
  } ffrp_scale_req_t;

endpackage

### src/ffrp_channels.sv
// Handshake channel interfaces of the row packer.
interface ffrp_range_if;
  logic valid;
  logic ready;
  logic signed [ffrp_pkg::COORD_W-1:0] range_start;
  logic signed [ffrp_pkg::COORD_W-1:0] range_end;
  logic last_range;
  modport source (output valid, range_start, range_end, last_range, input ready);
  modport sink (input valid, range_start, range_end, last_range, output ready);
endinterface

interface ffrp_result_if;
  logic valid;
  logic ready;
  logic [ffrp_pkg::ROW_W-1:0] row_index;
  logic [ffrp_pkg::STATUS_W-1:0] status;
  modport source (output valid, row_index, status, input ready);
  modport sink (input valid, row_index, status, output ready);
endinterface

interface ffrp_cfg_if;
  logic valid;
  logic ready;
  logic [ffrp_pkg::CFG_IDX_W-1:0] index;
  logic [ffrp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/ffrp_scale_unit.sv
// Shared multiplier sequencer that turns one coordinate range into cells.
module ffrp_scale_unit #(
  parameter int CELL_W = 11
) (
  input  logic clk,
  input  logic rst,
  input  ffrp_pkg::ffrp_scale_req_t req,
  input  logic signed [ffrp_pkg::DIFF_W-1:0] s_diff,
  input  logic signed [ffrp_pkg::DIFF_W-1:0] e_diff,
  input  logic [ffrp_pkg::SCALE_W-1:0] scale,
  input  logic [CELL_W-1:0] cells,
  output logic done,
  output logic [CELL_W-1:0] start_cell,
  output logic [CELL_W-1:0] end_cell
);

  localparam int X_W = ffrp_pkg::RND_W + 1;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_SLO  = 3'd1;
  localparam logic [2:0] U_SHI  = 3'd2;
  localparam logic [2:0] U_SADD = 3'd3;
  localparam logic [2:0] U_ELO  = 3'd4;
  localparam logic [2:0] U_EHI  = 3'd5;
  localparam logic [2:0] U_EADD = 3'd6;
  localparam logic [2:0] U_FIN  = 3'd7;

  logic [2:0] step;
  logic [ffrp_pkg::DIFF_W-1:0] mag_s;
  logic [ffrp_pkg::DIFF_W-1:0] mag_e;
  logic e_neg;
  logic pad_q;
  logic [ffrp_pkg::PROD_W-1:0] prod;
  logic [ffrp_pkg::ACC_W-1:0] acc;
  logic [ffrp_pkg::RND_W-1:0] r_s;
  logic [ffrp_pkg::RND_W-1:0] r_e;

  logic [ffrp_pkg::PART_W-1:0] mul_op;
  logic [ffrp_pkg::PROD_W-1:0] mul_res;
  logic [ffrp_pkg::ACC_W-1:0] sum;
  logic [X_W-1:0] ce_val;
  logic [X_W-1:0] ce_cap;
  logic empty;

  always_comb begin
    case (step)
      U_SLO: mul_op = mag_s[ffrp_pkg::PART_W-1:0];
      U_SHI: mul_op = {1'b0, mag_s[ffrp_pkg::DIFF_W-1:ffrp_pkg::PART_W]};
      U_ELO: mul_op = mag_e[ffrp_pkg::PART_W-1:0];
      U_EHI: mul_op = {1'b0, mag_e[ffrp_pkg::DIFF_W-1:ffrp_pkg::PART_W]};
      default: mul_op = '0;
    endcase
  end

  assign mul_res = ffrp_pkg::PROD_W'(mul_op) * ffrp_pkg::PROD_W'(scale);
  assign sum = acc + (ffrp_pkg::ACC_W'(prod) << ffrp_pkg::PART_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= U_IDLE;
    end else begin
      unique case (step)
        U_IDLE: begin
          if (req.start) begin
            mag_s <= s_diff[ffrp_pkg::DIFF_W-1] ? '0 : s_diff;
            mag_e <= e_diff[ffrp_pkg::DIFF_W-1] ? -e_diff : e_diff;
            e_neg <= e_diff[ffrp_pkg::DIFF_W-1];
            pad_q <= req.pad;
            step <= U_SLO;
          end
        end
        U_SLO: begin
          prod <= mul_res;
          step <= U_SHI;
        end
        U_SHI: begin
          acc <= ffrp_pkg::ACC_W'(prod) + ffrp_pkg::ROUND_HALF;
          prod <= mul_res;
          step <= U_SADD;
        end
        U_SADD: begin
          r_s <= sum[ffrp_pkg::ACC_W-1:ffrp_pkg::FRAC_W];
          step <= U_ELO;
        end
        U_ELO: begin
          prod <= mul_res;
          step <= U_EHI;
        end
        U_EHI: begin
          acc <= ffrp_pkg::ACC_W'(prod) + ffrp_pkg::ROUND_HALF;
          prod <= mul_res;
          step <= U_EADD;
        end
        U_EADD: begin
          r_e <= sum[ffrp_pkg::ACC_W-1:ffrp_pkg::FRAC_W];
          step <= U_FIN;
        end
        U_FIN: step <= U_IDLE;
        default: step <= U_IDLE;
      endcase
    end
  end

  // A negative end only survives as the padding cell when it rounds to zero.
  always_comb begin
    if (e_neg) begin
      ce_val = ((r_e == '0) && pad_q) ? X_W'(1) : X_W'(0);
    end else begin
      ce_val = X_W'(r_e) + X_W'(pad_q);
    end
    ce_cap = (ce_val > X_W'(cells)) ? X_W'(cells) : ce_val;
    empty = ce_cap <= X_W'(r_s);
  end

  assign done = (step == U_FIN);
  assign start_cell = empty ? '0 : r_s[CELL_W-1:0];
  assign end_cell = empty ? '0 : ce_cap[CELL_W-1:0];

endmodule

### src/ffrp_word_mask.sv
// Cell mask of all buffered ranges over one 64-cell word of a row.
module ffrp_word_mask #(
  parameter int CELL_W = 11,
  parameter int WW = 4,
  parameter int NR = 4,
  parameter int PW = 3
) (
  input  logic [WW-1:0] word_idx,
  input  logic [CELL_W-1:0] pend_start [NR],
  input  logic [CELL_W-1:0] pend_end [NR],
  input  logic [PW-1:0] pend_count,
  output logic [ffrp_pkg::WORD_W-1:0] mask
);

  localparam int CW = (WW + ffrp_pkg::WORD_SH > CELL_W) ? WW + ffrp_pkg::WORD_SH : CELL_W;

  logic [CW-1:0] base;

  assign base = CW'(word_idx) << ffrp_pkg::WORD_SH;

  always_comb begin
    mask = '0;
    for (int i = 0; i < NR; i++) begin
      for (int j = 0; j < ffrp_pkg::WORD_W; j++) begin
        if ((PW'(i) < pend_count) && ((base | CW'(j)) >= CW'(pend_start[i]))
            && ((base | CW'(j)) < CW'(pend_end[i]))) begin
          mask[j] = 1'b1;
        end
      end
    end
  end

endmodule

### src/ffrp_occ_mem.sv
// Occupancy memory with one address, registered read data.
module ffrp_occ_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic clk,
  input  logic we,
  input  logic re,
  input  logic [AW-1:0] addr,
  input  logic [ffrp_pkg::WORD_W-1:0] wdata,
  output logic [ffrp_pkg::WORD_W-1:0] rdata
);

  logic [ffrp_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### src/first_fit_interval_row_packer.sv
// Top level of the first-fit interval row packer.
// A range runs through the shared multiplier, start then end; a last range adds placement.
// Placement reads and checks each occupancy word (words per row = ceil(MAX_CELLS/64)),
// over open rows till one fits, then marks each word by read and write, or writes a new row.
// Throughput is one range at a time; the memory port is the limit during placement.
// Reset clears control state only; a row's words are all written when it is opened.
`include "first_fit_interval_row_packer_defines.svh"
module first_fit_interval_row_packer #(
  parameter int MAX_ROWS   = ffrp_pkg::DEF_MAX_ROWS,
  parameter int MAX_CELLS  = ffrp_pkg::DEF_MAX_CELLS,
  parameter int MAX_RANGES = ffrp_pkg::DEF_MAX_RANGES
) (
  input logic clk,
  input logic rst,
  ffrp_cfg_if.sink cfg,
  ffrp_range_if.sink rng,
  ffrp_result_if.source res
);

  localparam int WPR    = (MAX_CELLS + 63) / 64;
  localparam int WW     = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int DEPTH  = MAX_ROWS * WPR;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CELL_W = $clog2(MAX_CELLS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int PW     = $clog2(MAX_RANGES + 1);
  localparam int PI     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CONV   = 4'd1;
  localparam logic [3:0] S_PLACE  = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_MRD    = 4'd6;
  localparam logic [3:0] S_MWR    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic signed [ffrp_pkg::COORD_W-1:0] win_start;
  logic [ffrp_pkg::SCALE_W-1:0] scale_q24;
  logic [ffrp_pkg::CELLS_W-1:0] cells_in_row;
  logic [ffrp_pkg::ROWS_W-1:0] max_rows;
  logic allow_overflow;
  logic do_padding;
  logic force_new_row;

  logic [3:0] state;
  logic [CELL_W-1:0] pend_start [MAX_RANGES];
  logic [CELL_W-1:0] pend_end [MAX_RANGES];
  logic [PW-1:0] pend_count;
  logic pend_dropped;
  logic last_q;
  logic [RW-1:0] rows_open;
  logic [AW:0] open_base;
  logic layout_full;
  logic [RW-1:0] row_q;
  logic [AW-1:0] base_addr;
  logic [WW-1:0] word_idx;
  logic new_row_q;
  logic [RW-1:0] out_row;
  logic [ffrp_pkg::STATUS_W-1:0] out_st;
  logic res_valid;
  logic [ffrp_pkg::ROW_W-1:0] res_row;
  logic [ffrp_pkg::STATUS_W-1:0] res_status;

  logic [CELL_W-1:0] eff_cells;
  logic [RW-1:0] eff_rows;
  logic accept;
  logic buf_full;
  logic signed [ffrp_pkg::DIFF_W-1:0] s_diff;
  logic signed [ffrp_pkg::DIFF_W-1:0] e_diff;
  ffrp_pkg::ffrp_scale_req_t scale_req;
  logic scale_done;
  logic [CELL_W-1:0] cell_s;
  logic [CELL_W-1:0] cell_e;
  logic [ffrp_pkg::WORD_W-1:0] mask;
  logic [ffrp_pkg::WORD_W-1:0] mem_rdata;
  logic [ffrp_pkg::WORD_W-1:0] mem_wdata;
  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic mem_re;
  logic word_last;
  logic [ffrp_pkg::STATUS_W-1:0] placed_st;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      scale_q24 <= ffrp_pkg::SCALE_RESET;
      cells_in_row <= ffrp_pkg::CELLS_RESET;
      max_rows <= ffrp_pkg::ROWS_RESET;
      allow_overflow <= 1'b0;
      do_padding <= 1'b1;
      force_new_row <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ffrp_pkg::REG_WIN_START:      win_start <= $signed(cfg.data);
        ffrp_pkg::REG_SCALE_Q24:      scale_q24 <= cfg.data[ffrp_pkg::SCALE_W-1:0];
        ffrp_pkg::REG_CELLS_IN_ROW:   cells_in_row <= cfg.data[ffrp_pkg::CELLS_W-1:0];
        ffrp_pkg::REG_MAX_ROWS:       max_rows <= cfg.data[ffrp_pkg::ROWS_W-1:0];
        ffrp_pkg::REG_ALLOW_OVERFLOW: allow_overflow <= cfg.data[0];
        ffrp_pkg::REG_DO_PADDING:     do_padding <= cfg.data[0];
        ffrp_pkg::REG_FORCE_NEW_ROW:  force_new_row <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign eff_cells = (32'(cells_in_row) > 32'(MAX_CELLS)) ? CELL_W'(MAX_CELLS)
                                                          : CELL_W'(cells_in_row);
  assign eff_rows = (32'(max_rows) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(max_rows);

  assign rng.ready = (state == S_IDLE);
  assign accept = rng.valid && rng.ready;
  assign buf_full = (32'(pend_count) >= 32'(MAX_RANGES));

  assign s_diff = $signed({rng.range_start[ffrp_pkg::COORD_W-1], rng.range_start})
                - $signed({win_start[ffrp_pkg::COORD_W-1], win_start});
  assign e_diff = $signed({rng.range_end[ffrp_pkg::COORD_W-1], rng.range_end})
                - $signed({win_start[ffrp_pkg::COORD_W-1], win_start});

  assign scale_req.start = accept && !buf_full;
  assign scale_req.pad = do_padding;

  ffrp_scale_unit #(
    .CELL_W(CELL_W)
  ) u_scale (
    .clk(clk),
    .rst(rst),
    .req(scale_req),
    .s_diff(s_diff),
    .e_diff(e_diff),
    .scale(scale_q24),
    .cells(eff_cells),
    .done(scale_done),
    .start_cell(cell_s),
    .end_cell(cell_e)
  );

  ffrp_word_mask #(
    .CELL_W(CELL_W),
    .WW(WW),
    .NR(MAX_RANGES),
    .PW(PW)
  ) u_mask (
    .word_idx(word_idx),
    .pend_start(pend_start),
    .pend_end(pend_end),
    .pend_count(pend_count),
    .mask(mask)
  );

  assign mem_addr = base_addr + AW'(word_idx);
  assign mem_re = (state == S_RD) || (state == S_MRD);
  assign mem_we = (state == S_MWR);
  assign mem_wdata = new_row_q ? mask : (mem_rdata | mask);

  ffrp_occ_mem #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .re(mem_re),
    .addr(mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign word_last = (32'(word_idx) == 32'(WPR - 1));
  assign placed_st = pend_dropped ? ffrp_pkg::ST_DROPPED : ffrp_pkg::ST_PLACED;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend_count <= '0;
      pend_dropped <= 1'b0;
      rows_open <= '0;
      open_base <= '0;
      layout_full <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= rng.last_range;
            if (buf_full) begin
              pend_dropped <= 1'b1;
              state <= rng.last_range ? S_PLACE : S_IDLE;
            end else begin
              state <= S_CONV;
            end
          end
        end
        S_CONV: begin
          if (scale_done) begin
            pend_start[pend_count[PI-1:0]] <= cell_s;
            pend_end[pend_count[PI-1:0]] <= cell_e;
            pend_count <= pend_count + PW'(1);
            state <= last_q ? S_PLACE : S_IDLE;
          end
        end
        S_PLACE: begin
          row_q <= '0;
          base_addr <= '0;
          word_idx <= '0;
          if (layout_full) begin
            out_row <= '0;
            out_st <= ffrp_pkg::ST_FULL;
            state <= S_DONE;
          end else if (force_new_row || (rows_open == '0)) begin
            state <= S_DECIDE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if ((mem_rdata & mask) != '0) begin
            word_idx <= '0;
            if (row_q + RW'(1) == rows_open) begin
              state <= S_DECIDE;
            end else begin
              row_q <= row_q + RW'(1);
              base_addr <= base_addr + AW'(WPR);
              state <= S_RD;
            end
          end else if (word_last) begin
            word_idx <= '0;
            new_row_q <= 1'b0;
            state <= S_MRD;
          end else begin
            word_idx <= word_idx + WW'(1);
            state <= S_RD;
          end
        end
        S_DECIDE: begin
          word_idx <= '0;
          if (rows_open >= eff_rows) begin
            if (allow_overflow) begin
              out_row <= rows_open;
              out_st <= ffrp_pkg::ST_OVERFLOW;
            end else begin
              layout_full <= 1'b1;
              out_row <= '0;
              out_st <= ffrp_pkg::ST_FULL;
            end
            state <= S_DONE;
          end else begin
            row_q <= rows_open;
            base_addr <= open_base[AW-1:0];
            rows_open <= rows_open + RW'(1);
            open_base <= open_base + (AW + 1)'(WPR);
            new_row_q <= 1'b1;
            state <= S_MWR;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (word_last) begin
            out_row <= row_q;
            out_st <= placed_st;
            state <= S_DONE;
          end else begin
            word_idx <= word_idx + WW'(1);
            state <= new_row_q ? S_MWR : S_MRD;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_row <= ffrp_pkg::ROW_W'(out_row);
            res_status <= out_st;
            pend_count <= '0;
            pend_dropped <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = res_valid;
  assign res.row_index = res_row;
  assign res.status = res_status;

  `FFRP_ASSERT(a_full_sticky, clk, rst, layout_full |=> layout_full)
  `FFRP_ASSERT(a_result_from_done, clk, rst, $rose(res_valid) |-> $past(state) == S_DONE)
  `FFRP_ASSERT_NEVER(a_rows_bound, clk, rst, rows_open > RW'(MAX_ROWS))

endmodule

### tb/first_fit_interval_row_packer_tb.sv
// Self-checking testbench of the first-fit interval row packer with its own packing predictor.
`timescale 1ns / 100ps
module first_fit_interval_row_packer_tb;
  import ffrp_pkg::*;

  localparam int NROWS = DEF_MAX_ROWS;
  localparam int NCELLS = DEF_MAX_CELLS;
  localparam int NRANGES = DEF_MAX_RANGES;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint ONE_Q24 = 64'd16777216;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [STATUS_W-1:0] status;
  } placement_t;

  logic clk = 1'b0;
  logic rst;

  ffrp_cfg_if cfg_ch();
  ffrp_range_if rng_ch();
  ffrp_result_if res_ch();

  first_fit_interval_row_packer dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .rng(rng_ch),
    .res(res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state and register copies.
  bit occ [NROWS][NCELLS];
  int rows_used;
  bit packer_full;
  int pend_lo [NRANGES];
  int pend_hi [NRANGES];
  int pend_n;
  bit pend_lost;
  longint m_win;
  longint unsigned m_scale;
  int m_cells;
  int m_rows;
  bit m_overflow;
  bit m_pad;
  bit m_force;

  placement_t placements_due[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_left = 0;

  function automatic longint scaled_cell(longint x);
    longint unsigned mag;
    longint unsigned r;
    mag = (x < 0) ? longint'(-x) : x;
    r = (mag * m_scale + (64'd1 << 23)) >> 24;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit row_clear(int r);
    for (int i = 0; i < pend_n; i++)
      for (int c = pend_lo[i]; c < pend_hi[i]; c++)
        if (c < NCELLS && occ[r][c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void mark_row(int r);
    for (int i = 0; i < pend_n; i++)
      for (int c = pend_lo[i]; c < pend_hi[i]; c++)
        if (c < NCELLS) occ[r][c] = 1'b1;
  endfunction

  function automatic void pack_range(logic signed [31:0] rs, logic signed [31:0] re, logic last);
    longint s;
    longint e;
    longint cs;
    longint ce;
    longint lim;
    int row;
    int st;
    bit found;
    placement_t p;
    s = longint'(rs) - m_win;
    e = longint'(re) - m_win;
    lim = (m_cells > NCELLS) ? NCELLS : m_cells;
    if (s < 0) s = 0;
    cs = scaled_cell(s);
    ce = scaled_cell(e) + (m_pad ? 1 : 0);
    if (ce > lim) ce = lim;
    if (ce < 0) ce = 0;
    if (ce <= cs) begin
      cs = 0;
      ce = 0;
    end
    if (pend_n >= NRANGES) begin
      pend_lost = 1'b1;
    end else begin
      pend_lo[pend_n] = int'(cs);
      pend_hi[pend_n] = int'(ce);
      pend_n++;
    end
    if (!last) return;
    row = 0;
    st = ST_PLACED;
    found = 1'b0;
    if (packer_full) begin
      st = ST_FULL;
    end else begin
      if (!m_force) begin
        for (int r = 0; r < rows_used && r < NROWS; r++) begin
          if (!found && row_clear(r)) begin
            found = 1'b1;
            row = r;
          end
        end
      end
      if (found) begin
        mark_row(row);
        st = pend_lost ? ST_DROPPED : ST_PLACED;
      end else if (rows_used >= ((m_rows > NROWS) ? NROWS : m_rows)) begin
        if (m_overflow) begin
          row = rows_used;
          st = ST_OVERFLOW;
        end else begin
          packer_full = 1'b1;
          row = 0;
          st = ST_FULL;
        end
      end else begin
        row = rows_used;
        rows_used++;
        mark_row(row);
        st = pend_lost ? ST_DROPPED : ST_PLACED;
      end
    end
    pend_n = 0;
    pend_lost = 1'b0;
    p.row = ROW_W'(row);
    p.status = STATUS_W'(st);
    placements_due.push_back(p);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_WIN_START: m_win = longint'(signed'(d));
      REG_SCALE_Q24: m_scale = d[SCALE_W-1:0];
      REG_CELLS_IN_ROW: m_cells = d[CELLS_W-1:0];
      REG_MAX_ROWS: m_rows = d[ROWS_W-1:0];
      REG_ALLOW_OVERFLOW: m_overflow = d[0];
      REG_DO_PADDING: m_pad = d[0];
      REG_FORCE_NEW_ROW: m_force = d[0];
      default: ;
    endcase
  endfunction

  // Registers are only written once every transaction in flight has finished.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    rng_ch.valid <= 1'b0;
    do @(posedge clk); while (placements_due.size() != 0 || !rng_ch.ready);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_range(logic signed [31:0] rs, logic signed [31:0] re, logic last);
    int gap;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      rng_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rng_ch.valid <= 1'b1;
    rng_ch.range_start <= rs;
    rng_ch.range_end <= re;
    rng_ch.last_range <= last;
    do @(posedge clk); while (!rng_ch.ready);
    pack_range(rs, re, last);
  endtask

  task automatic drain;
    rng_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(longint span);
    if ($urandom_range(9) == 0) return $urandom();
    return 32'(m_win + $urandom_range(0, int'(span)) - 40);
  endfunction

  task automatic send_group(int n);
    logic [31:0] s;
    longint span;
    span = (m_scale == 0) ? 1000 : (longint'(m_cells) * ONE_Q24) / longint'(m_scale);
    if (span > 100000) span = 100000;
    for (int i = 0; i < n; i++) begin
      s = pick_coord(span);
      if ($urandom_range(9) == 0) send_range(s, $urandom(), i == n - 1);
      else send_range(s, s + $urandom_range(0, int'(span / 6) + 2) - 8, i == n - 1);
    end
  endtask

  task automatic random_config;
    int k;
    k = $urandom_range(3);
    write_reg(REG_SCALE_Q24, (k == 0) ? 32'(ONE_Q24) : (k == 1) ? 32'(ONE_Q24 / 2) :
              (k == 2) ? 32'($urandom_range(1, 16777216)) : 32'(ONE_Q24 / 4));
    write_reg(REG_WIN_START, ($urandom_range(1) == 0) ? 32'd0 : $urandom());
    write_reg(REG_CELLS_IN_ROW, $urandom_range(1, 1024));
    write_reg(REG_MAX_ROWS, $urandom_range(1, 16));
    write_reg(REG_ALLOW_OVERFLOW, 32'd1);
    write_reg(REG_DO_PADDING, $urandom_range(1));
    write_reg(REG_FORCE_NEW_ROW, 32'($urandom_range(5) == 0));
  endtask

  task automatic test_defaults;
    send_range(32'sd0, 32'sd10, 1'b1);
    send_range(32'sd5, 32'sd20, 1'b1);
    send_range(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_range(32'sd100, 32'sd50, 1'b1);
    send_range(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    for (int i = 0; i < 5; i++) send_range(32'(300 + 20 * i), 32'(310 + 20 * i), i == 4);
    send_range(32'sd700, 32'sd900, 1'b0);
    send_range(32'sd40, 32'sd60, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes;
    write_reg(REG_SCALE_Q24, 32'(ONE_Q24 / 2));
    write_reg(REG_DO_PADDING, 32'd0);
    send_range(32'sd1, 32'sd3, 1'b1);
    send_range(-32'sd3, -32'sd1, 1'b1);
    write_reg(REG_SCALE_Q24, 32'd0);
    send_range(32'sd0, 32'sd1000, 1'b1);
    write_reg(REG_SCALE_Q24, 32'(ONE_Q24));
    write_reg(REG_WIN_START, 32'h8000_0000);
    send_range(32'h8000_0000, 32'h8000_0100, 1'b1);
    write_reg(REG_WIN_START, 32'h7FFF_FFFF);
    send_range(32'h7FFF_FF00, 32'h7FFF_FFFF, 1'b1);
    write_reg(REG_WIN_START, 32'd0);
    write_reg(REG_CELLS_IN_ROW, 32'd1);
    write_reg(REG_DO_PADDING, 32'd1);
    send_range(32'sd0, 32'sd0, 1'b1);
    write_reg(REG_CELLS_IN_ROW, 32'd2047);
    send_range(32'sd1000, 32'sd2000, 1'b1);
    write_reg(REG_CELLS_IN_ROW, 32'd1024);
    write_reg(REG_MAX_ROWS, 32'd0);
    write_reg(REG_ALLOW_OVERFLOW, 32'd1);
    send_range(32'sd0, 32'sd1023, 1'b1);
    write_reg(REG_MAX_ROWS, 32'd16);
    write_reg(REG_FORCE_NEW_ROW, 32'd1);
    send_range(32'sd900, 32'sd901, 1'b1);
    write_reg(REG_FORCE_NEW_ROW, 32'd0);
    drain();
  endtask

  task automatic test_random_traffic(int s_idle, int r_idle, int items);
    int sent;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < items) begin
      random_config();
      for (int g = 0; g < 25; g++) begin
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        send_group(n);
        sent += n;
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 3000;
    for (int g = 0; g < 20; g++) send_group(1);
    drain();
  endtask

  task automatic test_layout_full;
    write_reg(REG_WIN_START, 32'd0);
    write_reg(REG_SCALE_Q24, 32'(ONE_Q24));
    write_reg(REG_CELLS_IN_ROW, 32'd1024);
    write_reg(REG_MAX_ROWS, 32'd64);
    write_reg(REG_ALLOW_OVERFLOW, 32'd0);
    write_reg(REG_FORCE_NEW_ROW, 32'd1);
    for (int g = 0; g < 70; g++) send_range(32'sd0, 32'sd1023, 1'b1);
    write_reg(REG_FORCE_NEW_ROW, 32'd0);
    for (int g = 0; g < 4; g++) send_group(2);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (placements_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: row %0d status %0d", res_ch.row_index, res_ch.status);
      end else begin
        want = placements_due.pop_front();
        if (want.row !== res_ch.row_index || want.status !== res_ch.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected row %0d status %0d, got row %0d status %0d",
                     want.row, want.status, res_ch.row_index, res_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_interval_row_packer verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rng_ch.valid = 1'b0;
    rng_ch.range_start = '0;
    rng_ch.range_end = '0;
    rng_ch.last_range = 1'b0;
    res_ch.ready = 1'b0;
    rows_used = 0;
    packer_full = 1'b0;
    pend_n = 0;
    pend_lost = 1'b0;
    m_win = 0;
    m_scale = SCALE_RESET;
    m_cells = CELLS_RESET;
    m_rows = ROWS_RESET;
    m_overflow = 1'b0;
    m_pad = 1'b1;
    m_force = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 20;
    recv_idle = 30;
    test_defaults();
    test_register_extremes();
    test_random_traffic(33, 88, 500);
    test_random_traffic(88, 33, 450);
    test_random_traffic(0, 0, 450);
    test_backpressure();
    test_layout_full();
    drain();
    if (errors == 0 && placements_due.size() == 0) begin
      $display("first_fit_interval_row_packer verification clean");
    end else begin
      $display("first_fit_interval_row_packer verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/ffrp_pkg.sv
src/ffrp_channels.sv
src/ffrp_scale_unit.sv
src/ffrp_word_mask.sv
src/ffrp_occ_mem.sv
src/first_fit_interval_row_packer.sv
tb/first_fit_interval_row_packer_tb.sv
